>>> sv/aes_pkg.sv
package aes_pkg;

  localparam int MaxRounds = 14;
  localparam int RkDepth = MaxRounds + 1;
  localparam int RkAw = $clog2(RkDepth);
  localparam int CfgAw = 3;
  localparam int Nk4Rounds = 10;
  localparam int Nk6Rounds = 12;
  localparam int Nk8Rounds = 14;

  localparam logic [CfgAw-1:0] RegKey0 = 3'd0;
  localparam logic [CfgAw-1:0] RegKey1 = 3'd1;
  localparam logic [CfgAw-1:0] RegKey2 = 3'd2;
  localparam logic [CfgAw-1:0] RegKey3 = 3'd3;
  localparam logic [CfgAw-1:0] RegKeyLen = 3'd4;
  localparam logic [CfgAw-1:0] RegMode = 3'd5;
  localparam logic [CfgAw-1:0] RegIvHi = 3'd6;
  localparam logic [CfgAw-1:0] RegIvLo = 3'd7;

  localparam logic [1:0] KeyLen128 = 2'd0;
  localparam logic [1:0] KeyLen192 = 2'd1;

  typedef logic [127:0] blk_t;
  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic         we;
    logic [RkAw-1:0] waddr;
    blk_t         wdata;
    logic [RkAw-1:0] raddr;
  } rk_req_t;

  function automatic byte_t xt(input byte_t a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t gmul(input byte_t a, input byte_t b);
    byte_t r;
    byte_t p;
    r = 8'h00;
    p = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ p;
      p = xt(p);
    end
    gmul = r;
  endfunction

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam byte_t ISBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte i of the block sits at bits [127-8i -: 8]
  function automatic byte_t bget(input blk_t s, input int i);
    bget = s[127-8*i -: 8];
  endfunction

  function automatic blk_t enc_round(input blk_t s, input logic last);
    blk_t t;
    blk_t o;
    byte_t a0, a1, a2, a3;
    for (int c = 0; c < 4; c++)
      for (int row = 0; row < 4; row++)
        t[127-8*(row+4*c) -: 8] = SBOX[bget(s, row + 4*((c+row)%4))];
    o = t;
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = bget(t, 4*c); a1 = bget(t, 4*c+1); a2 = bget(t, 4*c+2); a3 = bget(t, 4*c+3);
        o[127-8*(4*c)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        o[127-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
        o[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
        o[127-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
    end
    enc_round = o;
  endfunction

  // inverse shift and substitute; key add and mix follow separately
  function automatic blk_t dec_sub(input blk_t s);
    blk_t t;
    for (int c = 0; c < 4; c++)
      for (int row = 0; row < 4; row++)
        t[127-8*(row+4*((c+row)%4)) -: 8] = ISBOX[bget(s, row + 4*c)];
    dec_sub = t;
  endfunction

  function automatic blk_t inv_mix(input blk_t s);
    blk_t o;
    byte_t a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = bget(s, 4*c); a1 = bget(s, 4*c+1); a2 = bget(s, 4*c+2); a3 = bget(s, 4*c+3);
      o[127-8*(4*c)   -: 8] = gmul(a0,8'd14)^gmul(a1,8'd11)^gmul(a2,8'd13)^gmul(a3,8'd9);
      o[127-8*(4*c+1) -: 8] = gmul(a0,8'd9)^gmul(a1,8'd14)^gmul(a2,8'd11)^gmul(a3,8'd13);
      o[127-8*(4*c+2) -: 8] = gmul(a0,8'd13)^gmul(a1,8'd9)^gmul(a2,8'd14)^gmul(a3,8'd11);
      o[127-8*(4*c+3) -: 8] = gmul(a0,8'd11)^gmul(a1,8'd13)^gmul(a2,8'd9)^gmul(a3,8'd14);
    end
    inv_mix = o;
  endfunction

endpackage

>>> sv/aes_rk_ram.sv
module aes_rk_ram (
  input  logic             clk,
  input  aes_pkg::rk_req_t req,
  output aes_pkg::blk_t    rdata
);
  import aes_pkg::*;

  blk_t mem [RkDepth];

  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    rdata <= mem[req.raddr];
  end

endmodule

>>> sv/aes_key_exp.sv
module aes_key_exp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [255:0]     key,
  input  logic [1:0]       key_len,
  output logic             busy,
  output logic             wr_en,
  output logic [aes_pkg::RkAw-1:0] wr_addr,
  output aes_pkg::blk_t    wr_data
);
  import aes_pkg::*;

  // one key word per cycle; the window holds the last eight words
  logic [31:0] win_r [8];
  logic [31:0] win_nxt [8];
  logic [5:0]  idx_r, idx_nxt;
  logic [5:0]  total_r, total_nxt;
  logic [3:0]  nk_r, nk_nxt;
  logic [2:0]  cnt_r, cnt_nxt;  // idx mod nk
  logic [7:0]  rcon_r, rcon_nxt;
  logic        busy_r, busy_nxt;
  logic [95:0] acc_r, acc_nxt;  // first three words of the current round key
  logic [31:0] t;
  logic [31:0] w_new;
  logic [31:0] w_old;

  assign busy = busy_r;

  always_comb begin
    t = win_r[0];
    if (cnt_r == 3'd0) t = sub_word({win_r[0][23:0], win_r[0][31:24]}) ^ {rcon_r, 24'h0};
    else if (nk_r == 4'd8 && cnt_r == 3'd4) t = sub_word(win_r[0]);
    w_old = win_r[nk_r[2:0] - 3'd1];
    w_new = w_old ^ t;
  end

  always_comb begin
    logic [31:0] w_cur;
    idx_nxt = idx_r;
    total_nxt = total_r;
    nk_nxt = nk_r;
    cnt_nxt = cnt_r;
    rcon_nxt = rcon_r;
    busy_nxt = busy_r;
    acc_nxt = acc_r;
    win_nxt = win_r;
    wr_en = 1'b0;
    wr_addr = RkAw'(idx_r[5:2]);
    w_cur = (idx_r < {2'b0, nk_r}) ? key[255 - 32*idx_r[2:0] -: 32] : w_new;
    wr_data = {acc_r, w_cur};
    if (start) begin
      busy_nxt = 1'b1;
      idx_nxt = 6'd0;
      rcon_nxt = 8'h01;
      if (key_len == KeyLen128) begin
        nk_nxt = 4'd4; total_nxt = 6'(4 * (Nk4Rounds + 1));
      end else if (key_len == KeyLen192) begin
        nk_nxt = 4'd6; total_nxt = 6'(4 * (Nk6Rounds + 1));
      end else begin
        nk_nxt = 4'd8; total_nxt = 6'(4 * (Nk8Rounds + 1));
      end
      cnt_nxt = 3'd0;
    end else if (busy_r) begin
      for (int k = 7; k > 0; k--) win_nxt[k] = win_r[k-1];
      win_nxt[0] = w_cur;
      acc_nxt = {acc_r[63:0], w_cur};
      if (idx_r >= {2'b0, nk_r}) begin
        if (cnt_r == 3'd0) rcon_nxt = xt(rcon_r);
      end
      cnt_nxt = (cnt_r == nk_r[2:0] - 3'd1) ? 3'd0 : cnt_r + 3'd1;
      if (idx_r < {2'b0, nk_r}) cnt_nxt = (idx_r + 6'd1 == {2'b0, nk_r}) ? 3'd0 : 3'd1;
      wr_en = (idx_r[1:0] == 2'd3);
      idx_nxt = idx_r + 6'd1;
      if (idx_r + 6'd1 == total_r) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r <= '0;
      total_r <= '0;
      nk_r <= 4'd4;
      cnt_r <= '0;
      rcon_r <= 8'h01;
    end else begin
      busy_r <= busy_nxt;
      idx_r <= idx_nxt;
      total_r <= total_nxt;
      nk_r <= nk_nxt;
      cnt_r <= cnt_nxt;
      rcon_r <= rcon_nxt;
    end
    acc_r <= acc_nxt;
    win_r <= win_nxt;
  end

endmodule

>>> sv/aes_ecb_cbc_block_engine.sv
// AES block engine, ECB or CBC, encrypt or decrypt, 128/192/256-bit keys.
// Configuration: write cfg_index/cfg_data on the cfg channel while idle;
// index 0..3 key words, 4 key length, 5 mode (bit0 decrypt, bit1 CBC),
// 6/7 IV. cfg_ready is always high.
// Input: one beat per 128-bit block (in_data_high/low, in_start_of_message).
// Output: one beat per block on out_result_high/low.
// Each block first expands the key into the round-key RAM, one key word a
// cycle, then runs the key add and the rounds, reading each round key from
// that RAM in a read state (S_RD) ahead of each round state (S_RND), then
// posts the result and raises out_valid. The key expander and the single
// RAM read port set how fast blocks go through. The result sits in an
// output register; the next block is accepted once that beat is taken.
// A stalled receiver holds the result and the chain; in_ready stays low.
// Reset (rst_n low, synchronous) clears the configuration registers and the
// chain to zero and returns to idle. The round-key RAM needs no clearing:
// every block rewrites it before use.
module aes_ecb_cbc_block_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_high,
  input  logic [63:0] in_data_low,
  input  logic        in_start_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [aes_pkg::CfgAw-1:0] cfg_index,
  input  logic [63:0] cfg_data
);
  import aes_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_KEY   = 5'b00010,
    S_RD    = 5'b00100,
    S_RND   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [63:0] key_r [4];
  logic [1:0]  klen_r;
  logic [1:0]  mode_r;
  logic [63:0] ivh_r, ivl_r;
  blk_t chain_r, chain_nxt;
  blk_t st_r, st_nxt;
  blk_t din_r;
  logic [3:0]  rnd_r, rnd_nxt;  // rounds done
  logic [3:0]  nr_r;
  blk_t res_r, res_nxt;
  logic        kx_start, kx_busy, kx_we;
  logic [RkAw-1:0] kx_addr;
  blk_t kx_data, rk;
  rk_req_t req;
  logic dec, cbc;

  assign dec = mode_r[0];
  assign cbc = mode_r[1];
  assign cfg_ready = 1'b1;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_result_high = res_r[127:64];
  assign out_result_low = res_r[63:0];

  aes_key_exp u_kx (
    .clk, .rst_n, .start(kx_start),
    .key({key_r[0], key_r[1], key_r[2], key_r[3]}),
    .key_len(klen_r), .busy(kx_busy), .wr_en(kx_we), .wr_addr(kx_addr), .wr_data(kx_data)
  );

  always_comb begin
    req.we = kx_we;
    req.waddr = kx_addr;
    req.wdata = kx_data;
    // round key for the current round: rnd_r counts rounds done
    req.raddr = dec ? RkAw'(nr_r - rnd_r) : RkAw'(rnd_r);
  end

  aes_rk_ram u_ram (.clk, .req, .rdata(rk));

  always_comb begin
    blk_t ds;
    state_nxt = state_r;
    chain_nxt = chain_r;
    st_nxt = st_r;
    rnd_nxt = rnd_r;
    res_nxt = res_r;
    kx_start = 1'b0;
    ds = dec_sub(st_r) ^ rk;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kx_start = 1'b1;
          rnd_nxt = 4'd0;
          if (cbc && in_start_of_message) chain_nxt = {ivh_r, ivl_r};
          state_nxt = S_KEY;
        end
      end
      S_KEY: begin
        rnd_nxt = 4'd0;
        st_nxt = (cbc && !dec) ? (din_r ^ chain_r) : din_r;
        if (!kx_busy) state_nxt = S_RD;
      end
      S_RD: state_nxt = S_RND;
      S_RND: begin
        state_nxt = S_RD;
        rnd_nxt = rnd_r + 4'd1;
        if (rnd_r == 4'd0) st_nxt = st_r ^ rk;
        else if (!dec) st_nxt = enc_round(st_r, 1'b0) ^ rk;
        else st_nxt = inv_mix(ds);
        if (rnd_r == nr_r) begin
          if (!dec) st_nxt = enc_round(st_r, 1'b1) ^ rk;
          else st_nxt = ds;
          state_nxt = S_OUT;
          if (!dec) begin
            res_nxt = st_nxt;
            if (cbc) chain_nxt = st_nxt;
          end else begin
            res_nxt = cbc ? (st_nxt ^ chain_r) : st_nxt;
            if (cbc) chain_nxt = din_r;
          end
        end
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      chain_r <= '0;
      for (int k = 0; k < 4; k++) key_r[k] <= '0;
      klen_r <= '0;
      mode_r <= '0;
      ivh_r <= '0;
      ivl_r <= '0;
      rnd_r <= '0;
      nr_r <= 4'(Nk4Rounds);
    end else begin
      state_r <= state_nxt;
      chain_r <= chain_nxt;
      rnd_r <= rnd_nxt;
      if (in_valid && in_ready)
        nr_r <= (klen_r == KeyLen128) ? 4'(Nk4Rounds) :
                (klen_r == KeyLen192) ? 4'(Nk6Rounds) : 4'(Nk8Rounds);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegKey0: key_r[0] <= cfg_data;
          RegKey1: key_r[1] <= cfg_data;
          RegKey2: key_r[2] <= cfg_data;
          RegKey3: key_r[3] <= cfg_data;
          RegKeyLen: klen_r <= cfg_data[1:0];
          RegMode: mode_r <= cfg_data[1:0];
          RegIvHi: ivh_r <= cfg_data;
          RegIvLo: ivl_r <= cfg_data;
          default: ;
        endcase
      end
    end
    st_r <= st_nxt;
    res_r <= res_nxt;
    if (in_valid && in_ready) din_r <= {in_data_high, in_data_low};
  end

  // hold the result while the receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(res_r))
    else $error("result changed under stall");
  // no new block while the key expander runs
  a_kx: assert property (@(posedge clk) disable iff (!rst_n)
    kx_busy |-> !in_ready)
    else $error("accept during key expansion");
  // round counter never passes the round count plus one
  a_rnd: assert property (@(posedge clk) disable iff (!rst_n)
    rnd_r <= nr_r + 4'd1)
    else $error("round counter overrun");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import aes_pkg::*;

  // cipher_mode codes: bit0 decrypt, bit1 CBC
  localparam logic [1:0] ModeEcbEnc = 2'd0;
  localparam logic [1:0] ModeEcbDec = 2'd1;
  localparam logic [1:0] ModeCbcEnc = 2'd2;
  localparam logic [1:0] ModeCbcDec = 2'd3;
  // key_length codes beyond the package ones; code 3 behaves as 256-bit
  localparam logic [1:0] KeyLen256 = 2'd2;
  localparam logic [1:0] KeyLenOdd = 2'd3;

  localparam int RandomBlocks = 900;
  localparam int CalmTail = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_data_high = '0;
  logic [63:0] in_data_low = '0;
  logic        in_start_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_result_high;
  logic [63:0] out_result_low;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CfgAw-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  aes_ecb_cbc_block_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_data_high(in_data_high), .in_data_low(in_data_low),
    .in_start_of_message(in_start_of_message),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_high(out_result_high), .out_result_low(out_result_low),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the configuration registers and the CBC chain
  logic [63:0]  key_words [4];
  logic [1:0]   key_len_q;
  logic [1:0]   mode_q;
  logic [63:0]  iv_hi_q;
  logic [63:0]  iv_lo_q;
  logic [127:0] chain_q;

  logic [127:0] round_keys [MaxRounds + 1];
  logic [7:0]   fwd_sub [256];
  logic [7:0]   inv_sub [256];

  logic [127:0] expected_blocks [$];

  int errors = 0;
  int blocks_sent = 0;
  int blocks_checked = 0;
  int cfg_writes = 0;
  bit calm = 1'b0;

  // ---------------------------------------------------------------------------
  // GF(2^8) arithmetic and the AES rounds, built from scratch
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ a;
      a = gf_dbl(a);
    end
    return acc;
  endfunction

  // a^254, which maps zero to zero as the S-box needs
  function automatic logic [7:0] gf_inv(input logic [7:0] a);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h01;
    p = a;
    for (int e = 254; e != 0; e = e >> 1) begin
      if (e & 1) r = gf_mul(r, p);
      p = gf_mul(p, p);
    end
    return r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] b, input int n);
    return 8'((b << n) | (b >> (8 - n)));
  endfunction

  function automatic logic [31:0] sub_bytes4(input logic [31:0] w);
    return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
  endfunction

  // Fill round_keys from the shadow key registers; return the round count
  function automatic int expand_schedule();
    logic [31:0] w [68];
    logic [31:0] t;
    logic [7:0]  rcon;
    int nk;
    int nr;
    nk = (key_len_q == KeyLen128) ? 4 : (key_len_q == KeyLen192) ? 6 : 8;
    nr = nk + 6;
    if (nr > MaxRounds) nr = MaxRounds;
    rcon = 8'h01;
    for (int i = 0; i < nk; i++)
      w[i] = (i % 2) ? key_words[i / 2][31:0] : key_words[i / 2][63:32];
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      t = w[i - 1];
      if (i % nk == 0) begin
        t = sub_bytes4({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
        rcon = gf_dbl(rcon);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_bytes4(t);
      end
      w[i] = w[i - nk] ^ t;
    end
    for (int r = 0; r <= nr; r++)
      round_keys[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
    return nr;
  endfunction

  function automatic logic [127:0] encipher(input logic [127:0] blk, input int nr);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] o;
    blk = blk ^ round_keys[0];
    for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8];
    for (int r = 1; r <= nr; r++) begin
      for (int i = 0; i < 16; i++) s[i] = fwd_sub[s[i]];
      for (int c = 0; c < 4; c++)
        for (int row = 0; row < 4; row++) t[row + 4 * c] = s[row + 4 * ((c + row) % 4)];
      for (int c = 0; c < 4; c++) begin
        a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
        if (r != nr) begin
          s[4 * c]     = gf_dbl(a0) ^ gf_dbl(a1) ^ a1 ^ a2 ^ a3;
          s[4 * c + 1] = a0 ^ gf_dbl(a1) ^ gf_dbl(a2) ^ a2 ^ a3;
          s[4 * c + 2] = a0 ^ a1 ^ gf_dbl(a2) ^ gf_dbl(a3) ^ a3;
          s[4 * c + 3] = gf_dbl(a0) ^ a0 ^ a1 ^ a2 ^ gf_dbl(a3);
        end else begin
          s[4 * c] = a0; s[4 * c + 1] = a1; s[4 * c + 2] = a2; s[4 * c + 3] = a3;
        end
      end
      for (int i = 0; i < 16; i++) s[i] = s[i] ^ round_keys[r][127 - 8 * i -: 8];
    end
    for (int i = 0; i < 16; i++) o[127 - 8 * i -: 8] = s[i];
    return o;
  endfunction

  function automatic logic [127:0] decipher(input logic [127:0] blk, input int nr);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] o;
    blk = blk ^ round_keys[nr];
    for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8];
    for (int r = nr - 1; r >= 0; r--) begin
      for (int c = 0; c < 4; c++)
        for (int row = 0; row < 4; row++) t[row + 4 * ((c + row) % 4)] = s[row + 4 * c];
      for (int i = 0; i < 16; i++) s[i] = inv_sub[t[i]] ^ round_keys[r][127 - 8 * i -: 8];
      if (r != 0) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
          s[4 * c]     = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13) ^
                         gf_mul(a3, 8'd9);
          s[4 * c + 1] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11) ^
                         gf_mul(a3, 8'd13);
          s[4 * c + 2] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14) ^
                         gf_mul(a3, 8'd11);
          s[4 * c + 3] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9) ^
                         gf_mul(a3, 8'd14);
        end
      end
    end
    for (int i = 0; i < 16; i++) o[127 - 8 * i -: 8] = s[i];
    return o;
  endfunction

  // Work out the result of one accepted block and advance the chain
  function automatic logic [127:0] crypt_block(input logic [127:0] blk, input logic sof);
    logic [127:0] res;
    logic decrypt;
    logic cbc;
    int nr;
    decrypt = mode_q[0];
    cbc = mode_q[1];
    nr = expand_schedule();
    // start of message only reloads the chain in CBC; ECB leaves it alone
    if (cbc && sof) chain_q = {iv_hi_q, iv_lo_q};
    if (!decrypt) begin
      res = encipher(cbc ? (blk ^ chain_q) : blk, nr);
      if (cbc) chain_q = res;
    end else begin
      res = decipher(blk, nr);
      if (cbc) begin
        res = res ^ chain_q;
        chain_q = blk;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: check each beat, stall the receiver in random bursts
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want,
             blocks_checked);
    errors++;
  endtask

  int stall_left = 0;

  always @(posedge clk) begin
    logic [127:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_blocks.size() == 0) begin
        report_mismatch("unexpected result_high", out_result_high, 64'h0);
      end else begin
        want = expected_blocks.pop_front();
        if (out_result_high !== want[127:64])
          report_mismatch("result_high", out_result_high, want[127:64]);
        if (out_result_low !== want[63:0])
          report_mismatch("result_low", out_result_low, want[63:0]);
      end
      blocks_checked++;
    end
    // hold ready low for the rest of a burst, else start one now and then
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Send side
  // ---------------------------------------------------------------------------
  // Drop valid and wait until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write one register with the block idle; mirror it in the shadow copy
  task automatic write_reg(input logic [CfgAw-1:0] idx, input logic [63:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      RegKey0:   key_words[0] = val;
      RegKey1:   key_words[1] = val;
      RegKey2:   key_words[2] = val;
      RegKey3:   key_words[3] = val;
      RegKeyLen: key_len_q = val[1:0];
      RegMode:   mode_q = val[1:0];
      RegIvHi:   iv_hi_q = val;
      RegIvLo:   iv_lo_q = val;
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [255:0] key, input logic [1:0] klen,
                             input logic [1:0] mode, input logic [127:0] iv);
    write_reg(RegKey0, key[255:192]);
    write_reg(RegKey1, key[191:128]);
    write_reg(RegKey2, key[127:64]);
    write_reg(RegKey3, key[63:0]);
    write_reg(RegKeyLen, {62'h0, klen});
    write_reg(RegMode, {62'h0, mode});
    write_reg(RegIvHi, iv[127:64]);
    write_reg(RegIvLo, iv[63:0]);
  endtask

  // Present one block, hold it until accepted, then maybe idle for a burst.
  // Valid is left high so back-to-back beats never toggle it within a step.
  task automatic send_block(input logic [127:0] blk, input logic sof);
    in_valid <= 1'b1;
    in_data_high <= blk[127:64];
    in_data_low <= blk[63:0];
    in_start_of_message <= sof;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_blocks.push_back(crypt_block(blk, sof));
    blocks_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  function automatic logic [127:0] rand_block();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  localparam logic [255:0] StdKey =
      256'h000102030405060708090a0b0c0d0e0f101112131415161718191a1b1c1d1e1f;
  localparam logic [127:0] StdPlain = 128'h00112233445566778899aabbccddeeff;

  // Standard vectors and data extremes in ECB for every key length
  task automatic test_ecb_key_lengths();
    for (int k = 0; k < 3; k++) begin
      load_config(StdKey, 2'(k), ModeEcbEnc, '0);
      send_block(StdPlain, 1'b0);
      send_block('1, 1'b1);
      write_reg(RegMode, {62'h0, ModeEcbDec});
      send_block(StdPlain, 1'b0);
      send_block('0, 1'b1);
    end
    // key length code 3 runs as a 256-bit key; all-ones key too
    load_config('1, KeyLenOdd, ModeEcbEnc, '0);
    send_block(StdPlain, 1'b0);
  endtask

  // Chaining: IV reload, restart mid-stream, zero IV, and mode change
  // inside a message
  task automatic test_cbc_chaining();
    load_config(StdKey, KeyLen128, ModeCbcEnc, 128'h000102030405060708090a0b0c0d0e0f);
    send_block(StdPlain, 1'b1);
    send_block(rand_block(), 1'b0);
    send_block(rand_block(), 1'b1);
    write_reg(RegMode, {62'h0, ModeCbcDec});
    send_block(StdPlain, 1'b1);
    send_block(rand_block(), 1'b0);
    send_block(rand_block(), 1'b0);
    // switch to ECB mid-message, start flag ignored there, then back to CBC
    write_reg(RegMode, {62'h0, ModeEcbEnc});
    send_block(rand_block(), 1'b1);
    write_reg(RegMode, {62'h0, ModeCbcDec});
    send_block(rand_block(), 1'b0);
    // zero IV, all-ones IV
    load_config(StdKey, KeyLen256, ModeCbcEnc, '0);
    send_block('0, 1'b1);
    write_reg(RegIvHi, '1);
    write_reg(RegIvLo, '1);
    send_block('1, 1'b1);
  endtask

  // Random phases: fresh settings, then mostly well-formed messages
  task automatic test_random_messages();
    int target;
    int phase_end;
    int len;
    logic [255:0] key;
    logic [127:0] iv;
    logic [1:0] klen;
    target = blocks_sent + RandomBlocks;
    while (blocks_sent < target) begin
      key = {rand_block(), rand_block()};
      case ($urandom_range(0, 7))
        0: iv = '0;
        1: iv = '1;
        default: iv = rand_block();
      endcase
      klen = ($urandom_range(0, 9) == 0) ? KeyLenOdd : 2'($urandom_range(0, 2));
      load_config(key, klen, 2'($urandom_range(0, 3)), iv);
      phase_end = blocks_sent + $urandom_range(20, 60);
      while (blocks_sent < phase_end && blocks_sent < target) begin
        calm = (blocks_sent >= target - CalmTail);
        if ($urandom_range(0, 6) == 0) begin
          // noise: a lone block with a random start flag
          send_block(rand_block(), 1'($urandom));
        end else begin
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) send_block(rand_block(), i == 0);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] b;
    for (int i = 0; i < 256; i++) begin
      b = gf_inv(8'(i));
      fwd_sub[i] = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
    end
    for (int i = 0; i < 256; i++) inv_sub[fwd_sub[i]] = 8'(i);
    for (int i = 0; i < 4; i++) key_words[i] = '0;
    key_len_q = KeyLen128;
    mode_q = ModeEcbEnc;
    iv_hi_q = '0;
    iv_lo_q = '0;
    chain_q = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // the first block runs on the reset settings: all-zero key, ECB encrypt
    send_block('0, 1'b0);
    test_ecb_key_lengths();
    test_cbc_chaining();
    test_random_messages();
    drain();
    repeat (100) @(posedge clk);

    $display("Covered %0d blocks, %0d results checked, %0d register writes", blocks_sent,
             blocks_checked, cfg_writes);
    $display("Modes ECB/CBC encrypt/decrypt, key lengths 128/192/256 and code 3");
    if (errors == 0 && expected_blocks.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_blocks.size());
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Timeout with %0d results outstanding", expected_blocks.size());
    $display("testbench failed");
    $finish;
  end

endmodule
